// ----- rtl/core/hcth_pkg.sv -----
package hcth_pkg;

  // Field widths
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TempW    = 12;
  localparam int unsigned DeltaW   = 11;
  localparam int unsigned SecW     = 16;
  localparam int unsigned MsW      = 26;  // 65535 s * 1000 fits in 26 bits
  localparam int unsigned CmpW     = 14;  // target +/- delta without overflow
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned MsPerSec       = 1000;
  localparam int unsigned TestDurationMs = 10000;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_AUTO = 2'd1,
    MODE_HEAT = 2'd2,
    MODE_COOL = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACT_UPDATE    = 2'd0,
    ACT_TEST      = 2'd1,
    ACT_CANCEL    = 2'd2,
    ACT_FORCE_OFF = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    TEST_NONE   = 2'd0,
    TEST_HEATER = 2'd1,
    TEST_PUMP   = 2'd2
  } test_e;

  typedef enum logic [2:0] {
    RS_OFF   = 3'd0,
    RS_IDLE  = 3'd1,
    RS_HEAT  = 3'd2,
    RS_COOL  = 3'd3,
    RS_FAULT = 3'd4
  } run_e;

  typedef enum logic [1:0] {
    FK_NONE      = 2'd0,
    FK_SENSOR    = 2'd1,
    FK_INTERLOCK = 2'd2
  } fault_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_USER_MODE   = 3'd0,
    CFG_TARGET_TEMP = 3'd1,
    CFG_HEAT_DELTA  = 3'd2,
    CFG_COOL_DELTA  = 3'd3,
    CFG_HOLD_DELTA  = 3'd4,
    CFG_MIN_RUN     = 3'd5,
    CFG_MIN_OFF     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    mode_e                    user_mode;
    logic signed [TempW-1:0]  target_temp;
    logic [DeltaW-1:0]        heat_on_delta;
    logic [DeltaW-1:0]        cool_on_delta;
    logic [DeltaW-1:0]        hold_delta;
    logic [MsW-1:0]           min_run_ms;
    logic [MsW-1:0]           min_off_ms;
  } cfg_t;

  typedef struct packed {
    logic              heater;
    logic              pump;
    run_e              run_state;
    fault_e            fault;
    test_e             active_test;
    logic [TimeW-1:0]  test_end;
    logic [TimeW-1:0]  pump_on_time;
    logic [TimeW-1:0]  pump_off_time;
  } st_t;

  typedef struct packed {
    action_e                  action;
    logic [TimeW-1:0]         now_ms;
    logic                     sensor_ok;
    logic signed [TempW-1:0]  temp_reading;
    logic [1:0]               test_kind;
  } evt_t;

  typedef struct packed {
    logic    heater_on;
    logic    pump_on;
    run_e    run_state;
    fault_e  fault_kind;
    logic    test_accepted;
  } res_t;

endpackage

// ----- rtl/core/hcth_decide.sv -----
module hcth_decide #(
  parameter int unsigned TestDurationMs = hcth_pkg::TestDurationMs
) (
  input  hcth_pkg::cfg_t cfg_i,
  input  hcth_pkg::st_t  st_i,
  input  hcth_pkg::evt_t evt_i,
  output hcth_pkg::st_t  st_o,
  output hcth_pkg::res_t res_o
);

  logic signed [hcth_pkg::CmpW-1:0] tgt, temp;
  logic signed [hcth_pkg::CmpW-1:0] heat_start, heat_stop, cool_start, cool_stop;
  logic [hcth_pkg::TimeW-1:0]       on_elapsed, off_elapsed;
  logic                             heat_ok, cool_ok, min_run, min_off_done;
  logic                             hr, pr;

  assign tgt  = hcth_pkg::CmpW'(cfg_i.target_temp);
  assign temp = hcth_pkg::CmpW'(evt_i.temp_reading);

  assign heat_start = tgt - $signed({3'b000, cfg_i.heat_on_delta});
  assign heat_stop  = tgt - $signed({3'b000, cfg_i.hold_delta});
  assign cool_start = tgt + $signed({3'b000, cfg_i.cool_on_delta});
  assign cool_stop  = tgt + $signed({3'b000, cfg_i.hold_delta});

  assign on_elapsed  = evt_i.now_ms - st_i.pump_on_time;
  assign off_elapsed = evt_i.now_ms - st_i.pump_off_time;
  assign min_run      = st_i.pump &&
                        (on_elapsed < hcth_pkg::TimeW'(cfg_i.min_run_ms));
  assign min_off_done = off_elapsed >= hcth_pkg::TimeW'(cfg_i.min_off_ms);

  assign heat_ok = (cfg_i.user_mode == hcth_pkg::MODE_AUTO) ||
                   (cfg_i.user_mode == hcth_pkg::MODE_HEAT);
  assign cool_ok = (cfg_i.user_mode == hcth_pkg::MODE_AUTO) ||
                   (cfg_i.user_mode == hcth_pkg::MODE_COOL);

  // Hysteresis: running outputs hold until their stop threshold
  always_comb begin
    hr = 1'b0;
    pr = 1'b0;
    if (cool_ok && min_run) begin
      pr = 1'b1;
    end else if (st_i.pump && cool_ok && (temp > cool_stop)) begin
      pr = 1'b1;
    end else if (st_i.heater && heat_ok && (temp < heat_stop)) begin
      hr = 1'b1;
    end else if ((temp > cool_start) && cool_ok) begin
      pr = st_i.pump || min_off_done;
    end else if ((temp < heat_start) && heat_ok) begin
      hr = 1'b1;
    end
  end

  always_comb begin
    hcth_pkg::st_t    nxt;
    logic             drive_en, want_h, want_p, is_fault, acc;
    logic             nh, np;
    hcth_pkg::fault_e fcode;
    hcth_pkg::run_e   req;
    hcth_pkg::mode_e  dmode;

    nxt      = st_i;
    drive_en = 1'b0;
    want_h   = 1'b0;
    want_p   = 1'b0;
    is_fault = 1'b0;
    acc      = 1'b0;
    fcode    = hcth_pkg::FK_NONE;
    req      = hcth_pkg::RS_IDLE;
    dmode    = cfg_i.user_mode;

    unique case (evt_i.action)
      hcth_pkg::ACT_UPDATE: begin
        drive_en = 1'b1;
        if (st_i.active_test != hcth_pkg::TEST_NONE) begin
          nxt.active_test = hcth_pkg::TEST_NONE;
          if (!evt_i.sensor_ok) begin
            is_fault = 1'b1;
            fcode    = hcth_pkg::FK_SENSOR;
            req      = hcth_pkg::RS_FAULT;
          end else if ((cfg_i.user_mode == hcth_pkg::MODE_OFF) ||
                       (evt_i.now_ms >= st_i.test_end)) begin
            req = hcth_pkg::RS_IDLE;
          end else begin
            nxt.active_test = st_i.active_test;
            want_h = st_i.active_test == hcth_pkg::TEST_HEATER;
            want_p = st_i.active_test == hcth_pkg::TEST_PUMP;
            req    = want_h ? hcth_pkg::RS_HEAT : hcth_pkg::RS_COOL;
          end
        end else if (!evt_i.sensor_ok) begin
          is_fault = 1'b1;
          fcode    = hcth_pkg::FK_SENSOR;
          req      = hcth_pkg::RS_FAULT;
        end else if (cfg_i.user_mode == hcth_pkg::MODE_OFF) begin
          req = hcth_pkg::RS_OFF;
        end else begin
          want_h = hr;
          want_p = pr;
          req    = hr ? hcth_pkg::RS_HEAT : (pr ? hcth_pkg::RS_COOL : hcth_pkg::RS_IDLE);
        end
      end
      hcth_pkg::ACT_TEST: begin
        if (((evt_i.test_kind == 2'(hcth_pkg::TEST_HEATER)) ||
             (evt_i.test_kind == 2'(hcth_pkg::TEST_PUMP))) &&
            (st_i.active_test == hcth_pkg::TEST_NONE) && evt_i.sensor_ok &&
            (cfg_i.user_mode != hcth_pkg::MODE_OFF)) begin
          nxt.active_test = hcth_pkg::test_e'(evt_i.test_kind);
          nxt.test_end    = evt_i.now_ms + hcth_pkg::TimeW'(TestDurationMs);
          acc             = 1'b1;
        end
      end
      hcth_pkg::ACT_CANCEL: begin
        nxt.active_test = hcth_pkg::TEST_NONE;
        drive_en        = 1'b1;
        req             = hcth_pkg::RS_IDLE;
      end
      hcth_pkg::ACT_FORCE_OFF: begin
        nxt.active_test = hcth_pkg::TEST_NONE;
        drive_en        = 1'b1;
        dmode           = hcth_pkg::MODE_OFF;
        req             = hcth_pkg::RS_OFF;
      end
    endcase

    // Output stage: fault and mode override, heat/pump interlock
    nh = want_h;
    np = want_p;
    if (is_fault) begin
      nh    = 1'b0;
      np    = 1'b0;
      req   = hcth_pkg::RS_FAULT;
    end else if (dmode == hcth_pkg::MODE_OFF) begin
      nh    = 1'b0;
      np    = 1'b0;
      req   = hcth_pkg::RS_OFF;
      fcode = hcth_pkg::FK_NONE;
    end else if (want_h && want_p) begin
      nh    = 1'b0;
      np    = 1'b0;
      req   = hcth_pkg::RS_FAULT;
      fcode = hcth_pkg::FK_INTERLOCK;
    end else begin
      fcode = hcth_pkg::FK_NONE;
    end

    if (drive_en) begin
      if (st_i.pump != np) begin
        if (np) begin
          nxt.pump_on_time = evt_i.now_ms;
        end else begin
          nxt.pump_off_time = evt_i.now_ms;
        end
      end
      nxt.heater    = nh;
      nxt.pump      = np;
      nxt.run_state = req;
      nxt.fault     = fcode;
    end

    st_o = nxt;
    res_o.heater_on     = nxt.heater;
    res_o.pump_on       = nxt.pump;
    res_o.run_state     = nxt.run_state;
    res_o.fault_kind    = nxt.fault;
    res_o.test_accepted = acc;
  end

endmodule

// ----- rtl/core/heat_cool_thermostat_controller_core.sv -----
// Heater and cooling-pump thermostat with hysteresis. Each slave-side transaction is
// one event (update, test request, test cancel, force off) and yields exactly one
// master-side transaction with the heater and pump drives, the run state, the fault
// code and the test-accepted flag. The block takes one event per clock cycle unless
// the result side stalls; an accepted event lands in the input register, and its
// result is loaded into the result register once that register is free or being
// drained. The decision path between the two registers - the 32-bit elapsed-time
// compares for the pump minimum run and off times and the 14-bit threshold
// compares - sets the clock rate. Pump minimum times are converted to milliseconds
// when the register is written, so write configuration only while no event is in
// flight. Time stamps use wrapping 32-bit millisecond arithmetic; TestDurationMs
// sets how long an output test runs.
module heat_cool_thermostat_controller_core #(
  parameter int unsigned TestDurationMs = hcth_pkg::TestDurationMs
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Events
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: now_ms[31:0], sensor_ok[32], temp_reading[44:33], test_kind[46:45]
  input  logic [47:0]                       s_axis_tdata_i,
  // tuser: action[1:0]
  input  logic [1:0]                        s_axis_tuser_i,
  // Results
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: heater_on[0], pump_on[1], run_state[4:2], fault_kind[6:5],
  //        test_accepted[7]
  output logic [7:0]                        m_axis_tdata_o,
  // Configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [hcth_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [hcth_pkg::CfgDataW-1:0]     cfg_data_i
);

  hcth_pkg::evt_t evt_q, evt_d;
  hcth_pkg::res_t res_q, res_d;
  hcth_pkg::st_t  st_q, st_d;
  hcth_pkg::cfg_t cfg_q, cfg_d;
  logic           in_v_q, in_v_d;
  logic           out_v_q, out_v_d;
  logic           adv, s_acc;

  // Advance the held event whenever the result register is free or being drained
  assign adv             = in_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_v_q || adv;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // Unpack the event transaction
  always_comb begin
    evt_d.action       = hcth_pkg::action_e'(s_axis_tuser_i);
    evt_d.now_ms       = s_axis_tdata_i[31:0];
    evt_d.sensor_ok    = s_axis_tdata_i[32];
    evt_d.temp_reading = $signed(s_axis_tdata_i[44:33]);
    evt_d.test_kind    = s_axis_tdata_i[46:45];
  end

  always_comb begin
    in_v_d = in_v_q;
    if (s_acc) begin
      in_v_d = 1'b1;
    end else if (adv) begin
      in_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (adv) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_d = 1'b0;
    end
  end

  // Decision logic: next state and result for the held event
  hcth_decide #(
    .TestDurationMs (TestDurationMs)
  ) u_decide (
    .cfg_i (cfg_q),
    .st_i  (st_q),
    .evt_i (evt_q),
    .st_o  (st_d),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      st_q    <= '{heater: 1'b0, pump: 1'b0, run_state: hcth_pkg::RS_OFF,
                   fault: hcth_pkg::FK_NONE, active_test: hcth_pkg::TEST_NONE,
                   test_end: '0, pump_on_time: '0, pump_off_time: '0};
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
      if (adv) begin
        st_q <= st_d;
      end
    end
  end

  // Payload registers: hold until the next transaction moves them
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      evt_q <= evt_d;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {res_q.test_accepted, res_q.fault_kind, res_q.run_state,
                            res_q.pump_on, res_q.heater_on};

  // Configuration: always ready; minimum pump times are stored in milliseconds
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hcth_pkg::CFG_USER_MODE:   cfg_d.user_mode     = hcth_pkg::mode_e'(cfg_data_i[1:0]);
        hcth_pkg::CFG_TARGET_TEMP: cfg_d.target_temp   =
                                     $signed(cfg_data_i[hcth_pkg::TempW-1:0]);
        hcth_pkg::CFG_HEAT_DELTA:  cfg_d.heat_on_delta = cfg_data_i[hcth_pkg::DeltaW-1:0];
        hcth_pkg::CFG_COOL_DELTA:  cfg_d.cool_on_delta = cfg_data_i[hcth_pkg::DeltaW-1:0];
        hcth_pkg::CFG_HOLD_DELTA:  cfg_d.hold_delta    = cfg_data_i[hcth_pkg::DeltaW-1:0];
        hcth_pkg::CFG_MIN_RUN:     cfg_d.min_run_ms    =
          hcth_pkg::MsW'(cfg_data_i) * hcth_pkg::MsW'(hcth_pkg::MsPerSec);
        hcth_pkg::CFG_MIN_OFF:     cfg_d.min_off_ms    =
          hcth_pkg::MsW'(cfg_data_i) * hcth_pkg::MsW'(hcth_pkg::MsPerSec);
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{user_mode: hcth_pkg::MODE_OFF, target_temp: 12'sd320,
                 heat_on_delta: 11'd8, cool_on_delta: 11'd8, hold_delta: 11'd2,
                 min_run_ms: '0, min_off_ms: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- tb/heat_cool_thermostat_controller_checker.sv -----
`timescale 1ns / 100ps

module heat_cool_thermostat_controller_checker
  import hcth_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                evt_valid_i,
  input  logic                evt_ready_i,
  input  logic [47:0]         evt_data_i,
  input  logic [1:0]          evt_user_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  logic [7:0]          res_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  typedef struct {
    logic   heater;
    logic   pump;
    run_e   run;
    fault_e fault;
    logic   accepted;
  } outcome_t;

  // Register copy
  mode_e                   mode_r;
  logic signed [TempW-1:0] target_r;
  logic [DeltaW-1:0]       heat_delta_r;
  logic [DeltaW-1:0]       cool_delta_r;
  logic [DeltaW-1:0]       hold_delta_r;
  logic [SecW-1:0]         min_run_s_r;
  logic [SecW-1:0]         min_off_s_r;

  // Controller state copy
  logic             heat_q;
  logic             pump_q;
  run_e             run_q;
  fault_e           fault_q;
  test_e            test_q;
  logic [TimeW-1:0] test_end_q;
  logic [TimeW-1:0] pump_on_ms;
  logic [TimeW-1:0] pump_off_ms;

  outcome_t expected_outcomes[$];
  outcome_t oldest;
  int       mismatch_count;

  // Resolve the requested drives against fault, mode off and the interlock.
  function automatic void set_drives(logic [TimeW-1:0] now, mode_e mode, logic want_heat,
                                     logic want_pump, logic sensor_fault, run_e req_run);
    logic   nh;
    logic   np;
    run_e   ns;
    fault_e nf;
    nh = want_heat;
    np = want_pump;
    ns = req_run;
    nf = FK_NONE;
    if (sensor_fault) begin
      nh = 1'b0;
      np = 1'b0;
      ns = RS_FAULT;
      nf = FK_SENSOR;
    end else if (mode == MODE_OFF) begin
      nh = 1'b0;
      np = 1'b0;
      ns = RS_OFF;
    end else if (want_heat && want_pump) begin
      nh = 1'b0;
      np = 1'b0;
      ns = RS_FAULT;
      nf = FK_INTERLOCK;
    end
    if (pump_q != np) begin
      if (np) pump_on_ms = now;
      else pump_off_ms = now;
    end
    heat_q  = nh;
    pump_q  = np;
    run_q   = ns;
    fault_q = nf;
  endfunction

  function automatic void evaluate_update(logic [TimeW-1:0] now, logic ok, int temp);
    logic             heat_ok;
    logic             cool_ok;
    logic             want_heat;
    logic             want_pump;
    logic             min_run;
    logic             min_off_done;
    int               heat_start;
    int               heat_stop;
    int               cool_start;
    int               cool_stop;
    logic [TimeW-1:0] run_limit;
    logic [TimeW-1:0] off_limit;
    logic [TimeW-1:0] on_elapsed;
    logic [TimeW-1:0] off_elapsed;
    run_e             rs;
    if (test_q != TEST_NONE) begin
      if (!ok) begin
        test_q = TEST_NONE;
        set_drives(now, mode_r, 1'b0, 1'b0, 1'b1, RS_FAULT);
      end else if (mode_r == MODE_OFF || now >= test_end_q) begin
        test_q = TEST_NONE;
        set_drives(now, mode_r, 1'b0, 1'b0, 1'b0, RS_IDLE);
      end else begin
        set_drives(now, mode_r, test_q == TEST_HEATER, test_q == TEST_PUMP, 1'b0,
                   (test_q == TEST_HEATER) ? RS_HEAT : RS_COOL);
      end
    end else if (!ok) begin
      set_drives(now, mode_r, 1'b0, 1'b0, 1'b1, RS_FAULT);
    end else if (mode_r == MODE_OFF) begin
      set_drives(now, mode_r, 1'b0, 1'b0, 1'b0, RS_OFF);
    end else begin
      heat_ok      = (mode_r == MODE_AUTO) || (mode_r == MODE_HEAT);
      cool_ok      = (mode_r == MODE_AUTO) || (mode_r == MODE_COOL);
      heat_start   = int'(target_r) - int'(heat_delta_r);
      heat_stop    = int'(target_r) - int'(hold_delta_r);
      cool_start   = int'(target_r) + int'(cool_delta_r);
      cool_stop    = int'(target_r) + int'(hold_delta_r);
      run_limit    = min_run_s_r * 32'd1000;
      off_limit    = min_off_s_r * 32'd1000;
      on_elapsed   = now - pump_on_ms;
      off_elapsed  = now - pump_off_ms;
      min_run      = pump_q && (on_elapsed < run_limit);
      min_off_done = off_elapsed >= off_limit;
      want_heat    = 1'b0;
      want_pump    = 1'b0;
      if (cool_ok && min_run) begin
        want_pump = 1'b1;
      end else if (pump_q && cool_ok && temp > cool_stop) begin
        want_pump = 1'b1;
      end else if (heat_q && heat_ok && temp < heat_stop) begin
        want_heat = 1'b1;
      end else if (temp > cool_start && cool_ok) begin
        want_pump = pump_q || min_off_done;
      end else if (temp < heat_start && heat_ok) begin
        want_heat = 1'b1;
      end
      rs = want_heat ? RS_HEAT : (want_pump ? RS_COOL : RS_IDLE);
      set_drives(now, mode_r, want_heat, want_pump, 1'b0, rs);
    end
  endfunction

  function automatic outcome_t predict_event(action_e act, logic [TimeW-1:0] now, logic ok,
                                             int temp, logic [1:0] kind);
    outcome_t o;
    logic     accepted;
    accepted = 1'b0;
    case (act)
      ACT_UPDATE: evaluate_update(now, ok, temp);
      ACT_TEST: begin
        if ((kind == TEST_HEATER || kind == TEST_PUMP) && test_q == TEST_NONE && ok &&
            mode_r != MODE_OFF) begin
          test_q     = test_e'(kind);
          test_end_q = now + TimeW'(TestDurationMs);
          accepted   = 1'b1;
        end
      end
      ACT_CANCEL: begin
        test_q = TEST_NONE;
        set_drives(now, mode_r, 1'b0, 1'b0, 1'b0, RS_IDLE);
      end
      default: begin
        test_q = TEST_NONE;
        set_drives(now, MODE_OFF, 1'b0, 1'b0, 1'b0, RS_OFF);
      end
    endcase
    o.heater   = heat_q;
    o.pump     = pump_q;
    o.run      = run_q;
    o.fault    = fault_q;
    o.accepted = accepted;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_r         = MODE_OFF;
      target_r       = 12'sd320;
      heat_delta_r   = 11'd8;
      cool_delta_r   = 11'd8;
      hold_delta_r   = 11'd2;
      min_run_s_r    = '0;
      min_off_s_r    = '0;
      heat_q         = 1'b0;
      pump_q         = 1'b0;
      run_q          = RS_OFF;
      fault_q        = FK_NONE;
      test_q         = TEST_NONE;
      test_end_q     = '0;
      pump_on_ms     = '0;
      pump_off_ms    = '0;
      mismatch_count = 0;
      expected_outcomes.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_USER_MODE:   mode_r = mode_e'(cfg_data_i[1:0]);
          CFG_TARGET_TEMP: target_r = $signed(cfg_data_i[TempW-1:0]);
          CFG_HEAT_DELTA:  heat_delta_r = cfg_data_i[DeltaW-1:0];
          CFG_COOL_DELTA:  cool_delta_r = cfg_data_i[DeltaW-1:0];
          CFG_HOLD_DELTA:  hold_delta_r = cfg_data_i[DeltaW-1:0];
          CFG_MIN_RUN:     min_run_s_r = cfg_data_i[SecW-1:0];
          CFG_MIN_OFF:     min_off_s_r = cfg_data_i[SecW-1:0];
          default: ;
        endcase
      end

      // Retire results before queueing the new event so a stray result is never
      // matched against an expectation queued at the same edge.
      if (res_valid_i && res_ready_i) begin
        if (expected_outcomes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result %h at %0t", res_data_i, $time);
        end else begin
          oldest = expected_outcomes.pop_front();
          if (res_data_i[0] !== oldest.heater || res_data_i[1] !== oldest.pump ||
              res_data_i[4:2] !== oldest.run || res_data_i[6:5] !== oldest.fault ||
              res_data_i[7] !== oldest.accepted) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result mismatch at %0t: expected heater %0b pump %0b run %0d ",
                        "fault %0d accepted %0b, got heater %0b pump %0b run %0d ",
                        "fault %0d accepted %0b"},
                       $time, oldest.heater, oldest.pump, oldest.run, oldest.fault,
                       oldest.accepted, res_data_i[0], res_data_i[1], res_data_i[4:2],
                       res_data_i[6:5], res_data_i[7]);
          end
        end
      end

      if (evt_valid_i && evt_ready_i)
        expected_outcomes.push_back(predict_event(action_e'(evt_user_i), evt_data_i[31:0],
                                                  evt_data_i[32],
                                                  int'($signed(evt_data_i[44:33])),
                                                  evt_data_i[46:45]));

      mismatches_o <= mismatch_count;
      pending_o    <= expected_outcomes.size();
    end
  end

endmodule

// ----- tb/tb_heat_cool_thermostat_controller_core.sv -----
`timescale 1ns / 100ps

module tb_heat_cool_thermostat_controller_core;
  import hcth_pkg::*;

  localparam int         LimitCycles = 400000;
  // Test kind outside the defined set; a request with it must be refused.
  localparam logic [1:0] TestKindBad = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  // tdata: now_ms[31:0], sensor_ok[32], temp_reading[44:33], test_kind[46:45]
  logic [47:0]         s_axis_tdata_i;
  // tuser: action[1:0]
  logic [1:0]          s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  // tdata: heater_on[0], pump_on[1], run_state[4:2], fault_kind[6:5], test_accepted[7]
  logic [7:0]          m_axis_tdata_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int mismatches;
  int results_pending;

  // Traffic shaping for the sender and the receiver processes
  int idle_pct;
  int stall_pct;
  int hold_request;

  // Event generator state: running time stamp and temperature walk around the target
  logic [31:0] clock_ms;
  int          room;
  int          center;
  int          span;
  int          cycle_count;

  heat_cool_thermostat_controller_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  heat_cool_thermostat_controller_checker outcome_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_valid_i  (s_axis_tvalid_i),
    .evt_ready_i  (s_axis_tready_o),
    .evt_data_i   (s_axis_tdata_i),
    .evt_user_i   (s_axis_tuser_i),
    .res_valid_i  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_data_i   (m_axis_tdata_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Abort a hung run; the bound is far beyond the slowest legal run.
  initial begin
    cycle_count = 0;
    while (cycle_count < LimitCycles) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on request so that the
  // block backs up and drops its input ready.
  initial begin
    int hold_left;
    hold_left       = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offer one event and hold it until the transaction completes. Valid is left
  // high on return; the next call or the caller drops it.
  task automatic offer_event(action_e act, logic [31:0] now, logic ok, int temp,
                             logic [1:0] kind);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, kind, 12'(temp), ok, now};
    s_axis_tuser_i  <= act;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every event has produced its result.
  task automatic quiesce();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Write every register, then recenter the temperature walk on the new target.
  task automatic program_regs(mode_e mode, int target, int heat, int cool, int hold,
                              int run_s, int off_s);
    write_reg(CFG_USER_MODE, {14'd0, mode});
    write_reg(CFG_TARGET_TEMP, {4'd0, 12'(target)});
    write_reg(CFG_HEAT_DELTA, {5'd0, 11'(heat)});
    write_reg(CFG_COOL_DELTA, {5'd0, 11'(cool)});
    write_reg(CFG_HOLD_DELTA, {5'd0, 11'(hold)});
    write_reg(CFG_MIN_RUN, 16'(run_s));
    write_reg(CFG_MIN_OFF, 16'(off_s));
    cfg_valid_i <= 1'b0;
    center = target;
    span   = ((heat > cool) ? heat : cool) + hold + 16;
    room   = target;
  endtask

  function automatic int temp_clamp(int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  // Mostly control-tick spacing, now and then a long gap.
  task automatic advance_clock();
    if ($urandom_range(0, 19) == 0) clock_ms += $urandom_range(0, 70000);
    else clock_ms += $urandom_range(0, 2500);
  endtask

  task automatic walk_temp();
    room += int'($urandom_range(0, 12)) - 6;
    if ($urandom_range(0, 14) == 0) room = center - span + int'($urandom_range(0, 2 * span));
    if (room > center + span || room < center - span) room = center;
  endtask

  task automatic track_update();
    advance_clock();
    walk_temp();
    offer_event(ACT_UPDATE, clock_ms, $urandom_range(0, 19) != 0, temp_clamp(room),
                2'($urandom_range(0, 3)));
  endtask

  // Random traffic: mostly well-formed sequences (tracking runs, timed tests
  // with follow-up updates), the rest cancels, force-offs and raw noise.
  task automatic run_random(int count);
    int         sent;
    int         pick;
    int         len;
    logic [1:0] kind;
    logic [31:0] now;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = $urandom_range(3, 12);
        repeat (len) track_update();
        sent += len;
      end else if (pick < 80) begin
        if ($urandom_range(0, 7) == 0) kind = 2'($urandom_range(0, 3));
        else kind = $urandom_range(0, 1) ? TEST_HEATER : TEST_PUMP;
        advance_clock();
        offer_event(ACT_TEST, clock_ms, $urandom_range(0, 9) != 0, temp_clamp(room), kind);
        len = $urandom_range(2, 10);
        repeat (len) track_update();
        sent += len + 1;
        if ($urandom_range(0, 2) == 0) begin
          advance_clock();
          offer_event(ACT_CANCEL, clock_ms, 1'b1, temp_clamp(room), TEST_NONE);
          sent++;
        end
      end else if (pick < 90) begin
        advance_clock();
        offer_event($urandom_range(0, 1) ? ACT_CANCEL : ACT_FORCE_OFF, clock_ms,
                    $urandom_range(0, 1), temp_clamp(room), 2'($urandom_range(0, 3)));
        sent++;
      end else begin
        now = $urandom_range(0, 1) ? $urandom : clock_ms;
        clock_ms = now;
        offer_event(action_e'($urandom_range(0, 3)), now, $urandom_range(0, 1),
                    int'($urandom_range(0, 4095)) - 2048, 2'($urandom_range(0, 3)));
        sent++;
      end
    end
  endtask

  initial begin
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = ACT_UPDATE;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_USER_MODE;
    cfg_data_i      = '0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_request    = 0;
    clock_ms        = '0;
    center          = 320;
    span            = 32;
    room            = 320;
    rst_ni          = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: mode off, so updates report off and tests are refused
    offer_event(ACT_UPDATE, 32'd100, 1'b1, 320, TEST_NONE);
    offer_event(ACT_TEST, 32'd200, 1'b1, 320, TEST_HEATER);
    quiesce();

    // Auto mode around 20 C, pump minimum run 2 s and minimum off 3 s
    program_regs(MODE_AUTO, 320, 8, 8, 2, 2, 3);
    offer_event(ACT_UPDATE, 32'd1000, 1'b1, 320, TEST_NONE);   // inside the band: idle
    offer_event(ACT_UPDATE, 32'd2000, 1'b1, 300, TEST_NONE);   // below heat start
    offer_event(ACT_UPDATE, 32'd3000, 1'b1, 317, TEST_NONE);   // heat holds below stop
    offer_event(ACT_UPDATE, 32'd4000, 1'b1, 319, TEST_NONE);   // heat stops
    offer_event(ACT_UPDATE, 32'd5000, 1'b1, 330, TEST_NONE);   // pump starts
    offer_event(ACT_UPDATE, 32'd6000, 1'b1, 300, TEST_NONE);   // minimum run keeps pump
    offer_event(ACT_UPDATE, 32'd8000, 1'b1, 300, TEST_NONE);   // pump off, heat on
    offer_event(ACT_UPDATE, 32'd9000, 1'b1, 330, TEST_NONE);   // minimum off blocks pump
    offer_event(ACT_UPDATE, 32'd9500, 1'b0, 320, TEST_NONE);   // sensor fault
    offer_event(ACT_TEST, 32'd10000, 1'b1, 320, TEST_HEATER);  // accepted, outputs held
    offer_event(ACT_TEST, 32'd10500, 1'b1, 320, TEST_PUMP);    // refused, test running
    offer_event(ACT_UPDATE, 32'd11000, 1'b1, 320, TEST_NONE);  // heater test drives
    offer_event(ACT_UPDATE, 32'd20000, 1'b1, 320, TEST_NONE);  // test expires exactly
    offer_event(ACT_TEST, 32'd21000, 1'b1, 320, TEST_NONE);    // refused, no kind
    offer_event(ACT_TEST, 32'd21100, 1'b1, 320, TestKindBad);  // refused, bad kind
    offer_event(ACT_TEST, 32'd21200, 1'b0, 320, TEST_PUMP);    // refused, bad sensor
    offer_event(ACT_TEST, 32'd22000, 1'b1, 320, TEST_PUMP);
    offer_event(ACT_UPDATE, 32'd23000, 1'b1, 320, TEST_NONE);  // pump test drives
    offer_event(ACT_CANCEL, 32'd24000, 1'b1, 320, TEST_NONE);
    offer_event(ACT_TEST, 32'd25000, 1'b1, 320, TEST_HEATER);
    offer_event(ACT_UPDATE, 32'd26000, 1'b0, 320, TEST_NONE);  // sensor loss ends test
    offer_event(ACT_FORCE_OFF, 32'hFFFF_FFFF, 1'b1, 2047, TestKindBad);
    offer_event(ACT_UPDATE, 32'hFFFF_FFFF, 1'b1, -2048, TEST_NONE);
    offer_event(ACT_UPDATE, 32'd0, 1'b1, 2047, TEST_NONE);     // time wraps
    clock_ms = 32'd30000;

    for (int phase = 0; phase < 8; phase++) begin
      quiesce();
      case (phase)
        0: program_regs(MODE_AUTO, 320, 8, 8, 2, 2, 3);
        1: program_regs(MODE_HEAT, -2048, 0, 2047, 0, 0, 65535);
        2: program_regs(MODE_COOL, 2047, 2047, 0, 2047, 65535, 0);
        3: program_regs(MODE_AUTO, 0, 16, 16, 4, 1, 1);
        4: program_regs(MODE_OFF, 100, 5, 5, 1, 0, 0);
        5: program_regs(MODE_AUTO, -500, 30, 12, 6, 5, 2);
        6: program_regs(MODE_COOL, 800, 3, 20, 10, 3, 0);
        default: program_regs(MODE_AUTO, 1365, 1365, 682, 3, 10, 7);
      endcase
      case (phase % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 51;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 51;
        end
        default: begin
          idle_pct  = 8;
          stall_pct = 8;
        end
      endcase
      // Back up the block while the sender keeps pushing at full rate
      if (phase == 0 || phase == 4) hold_request = 64;
      // Run close to the time stamp wrap so elapsed times and test ends wrap
      if (phase == 5) clock_ms = 32'hFFFF_0000;
      run_random(156);
    end

    quiesce();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- heat_cool_thermostat_controller_core.f -----
rtl/core/hcth_pkg.sv
rtl/core/hcth_decide.sv
rtl/core/heat_cool_thermostat_controller_core.sv
tb/heat_cool_thermostat_controller_checker.sv
tb/tb_heat_cool_thermostat_controller_core.sv
